// ===== rtl/core/dpx_pkg.sv =====
// Shared types and constants for the data-processing execute block.
`default_nettype none

package dpx_pkg;

   localparam int WORD_BITS = 32;
   localparam logic [3:0] PC_REG = 4'hF;

   typedef enum logic [3:0] {
      OP_AND = 4'd0,
      OP_EOR = 4'd1,
      OP_SUB = 4'd2,
      OP_RSB = 4'd3,
      OP_ADD = 4'd4,
      OP_ADC = 4'd5,
      OP_SBC = 4'd6,
      OP_RSC = 4'd7,
      OP_TST = 4'd8,
      OP_TEQ = 4'd9,
      OP_CMP = 4'd10,
      OP_CMN = 4'd11,
      OP_ORR = 4'd12,
      OP_MOV = 4'd13,
      OP_BIC = 4'd14,
      OP_MVN = 4'd15
   } dp_opcode_type;

   typedef enum logic [1:0] {
      SH_LSL = 2'd0,
      SH_LSR = 2'd1,
      SH_ASR = 2'd2,
      SH_ROR = 2'd3
   } shift_kind_type;

   typedef enum logic [1:0] {
      ST_DONE       = 2'd0,
      ST_UNPRED     = 2'd1,
      ST_NOT_HANDLED = 2'd2
   } status_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] instr;
      logic [WORD_BITS-1:0] rn_value;
      logic [WORD_BITS-1:0] rm_value;
      logic [WORD_BITS-1:0] rs_value;
      logic [WORD_BITS-1:0] cpsr_in;
      logic [WORD_BITS-1:0] spsr_in;
      logic                 spsr_exists;
   } req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] result;
      logic [3:0]           dest_reg;
      logic                 write_reg;
      logic [WORD_BITS-1:0] cpsr_out;
      logic                 write_cpsr;
      logic [1:0]           status;
   } rsp_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] operand;
      logic                 carry;
   } shift_out_type;

endpackage

`default_nettype wire

// ===== rtl/core/dpx_shifter.sv =====
// Barrel shifter forming the shifter operand and its carry out.
`default_nettype none

module dpx_shifter
   import dpx_pkg::*;
(
   input  wire logic [WORD_BITS-1:0] instr,
   input  wire logic [WORD_BITS-1:0] rm,
   input  wire logic [WORD_BITS-1:0] rs,
   input  wire logic                 cin,
   output shift_out_type             shift
);

   shift_kind_type       kind;
   logic [7:0]           rs_amt;
   logic [4:0]           amt;
   logic [4:0]           rot;
   logic [WORD_BITS:0]   lsl_t;
   logic [WORD_BITS:0]   lsr_t;
   logic [WORD_BITS:0]   asr_t;
   logic [2*WORD_BITS-1:0] ror_t;
   logic [2*WORD_BITS-1:0] imm_t;
   logic [WORD_BITS-1:0] imm_word;
   logic [WORD_BITS-1:0] ror_v;
   logic [WORD_BITS-1:0] imm_v;
   logic [WORD_BITS-1:0] fill;
   logic                 rs_zero;
   logic                 rs_big;
   logic                 rs_eq32;

   always_comb begin
      kind     = shift_kind_type'(instr[6:5]);
      rs_amt   = rs[7:0];
      amt      = instr[4] ? rs_amt[4:0] : instr[11:7];
      rot      = {instr[11:8], 1'b0};
      imm_word = {{(WORD_BITS-8){1'b0}}, instr[7:0]};
      lsl_t    = {1'b0, rm} << amt;
      lsr_t    = {rm, 1'b0} >> amt;
      asr_t    = $signed({rm, 1'b0}) >>> amt;
      ror_t    = {rm, rm} >> amt;
      imm_t    = {imm_word, imm_word} >> rot;
      ror_v    = ror_t[WORD_BITS-1:0];
      imm_v    = imm_t[WORD_BITS-1:0];
      fill     = {WORD_BITS{rm[WORD_BITS-1]}};
      rs_zero  = (rs_amt == 8'd0);
      rs_big   = (rs_amt[7:5] != 3'd0);
      rs_eq32  = (rs_amt == 8'd32);

      shift.operand = rm;
      shift.carry   = cin;

      if (instr[25]) begin
         shift.operand = imm_v;
         shift.carry   = (rot == 5'd0) ? cin : imm_v[WORD_BITS-1];
      end else if (instr[4]) begin
         // Register-specified amount: the whole low byte of Rs counts.
         if (!rs_zero) begin
            case (kind)
               SH_LSL: begin
                  if (!rs_big) begin
                     shift.operand = lsl_t[WORD_BITS-1:0];
                     shift.carry   = lsl_t[WORD_BITS];
                  end else begin
                     shift.operand = '0;
                     shift.carry   = rs_eq32 ? rm[0] : 1'b0;
                  end
               end
               SH_LSR: begin
                  if (!rs_big) begin
                     shift.operand = lsr_t[WORD_BITS:1];
                     shift.carry   = lsr_t[0];
                  end else begin
                     shift.operand = '0;
                     shift.carry   = rs_eq32 ? rm[WORD_BITS-1] : 1'b0;
                  end
               end
               SH_ASR: begin
                  if (!rs_big) begin
                     shift.operand = asr_t[WORD_BITS:1];
                     shift.carry   = asr_t[0];
                  end else begin
                     shift.operand = fill;
                     shift.carry   = rm[WORD_BITS-1];
                  end
               end
               default: begin
                  if (amt == 5'd0) begin
                     shift.operand = rm;
                     shift.carry   = rm[WORD_BITS-1];
                  end else begin
                     shift.operand = ror_v;
                     shift.carry   = ror_v[WORD_BITS-1];
                  end
               end
            endcase
         end
      end else begin
         // Immediate amount; a zero amount has its own meaning per kind.
         case (kind)
            SH_LSL: begin
               if (amt != 5'd0) begin
                  shift.operand = lsl_t[WORD_BITS-1:0];
                  shift.carry   = lsl_t[WORD_BITS];
               end
            end
            SH_LSR: begin
               if (amt == 5'd0) begin
                  shift.operand = '0;
                  shift.carry   = rm[WORD_BITS-1];
               end else begin
                  shift.operand = lsr_t[WORD_BITS:1];
                  shift.carry   = lsr_t[0];
               end
            end
            SH_ASR: begin
               if (amt == 5'd0) begin
                  shift.operand = fill;
                  shift.carry   = rm[WORD_BITS-1];
               end else begin
                  shift.operand = asr_t[WORD_BITS:1];
                  shift.carry   = asr_t[0];
               end
            end
            default: begin
               if (amt == 5'd0) begin
                  // Rotate right extended through the carry flag.
                  shift.operand = {cin, rm[WORD_BITS-1:1]};
                  shift.carry   = rm[0];
               end else begin
                  shift.operand = ror_v;
                  shift.carry   = ror_v[WORD_BITS-1];
               end
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/dpx_alu.sv =====
// ALU, flag generation and status decode for one data-processing item.
`default_nettype none

module dpx_alu
   import dpx_pkg::*;
(
   input  wire req_type       item,
   input  wire shift_out_type shift,
   output rsp_type            rsp
);

   dp_opcode_type        op;
   logic [3:0]           rd;
   logic                 sbit;
   logic                 cflag;
   logic                 vflag;
   logic [WORD_BITS-1:0] add_a;
   logic [WORD_BITS-1:0] add_b;
   logic                 add_cin;
   logic [WORD_BITS:0]   sum;
   logic [WORD_BITS-1:0] res;
   logic                 c;
   logic                 v;
   logic                 arith;
   logic                 test_op;
   logic                 wreg;
   logic                 flags;
   logic [1:0]           st;
   logic [WORD_BITS-1:0] cpsr_o;
   logic                 wcpsr;

   always_comb begin
      op      = dp_opcode_type'(item.instr[24:21]);
      rd      = item.instr[15:12];
      sbit    = item.instr[20];
      cflag   = item.cpsr_in[29];
      vflag   = item.cpsr_in[28];
      test_op = (op == OP_TST) || (op == OP_TEQ) || (op == OP_CMP) || (op == OP_CMN);

      add_a   = item.rn_value;
      add_b   = shift.operand;
      add_cin = 1'b0;
      arith   = 1'b0;
      unique case (op)
         OP_SUB, OP_CMP: begin
            add_b = ~shift.operand; add_cin = 1'b1; arith = 1'b1;
         end
         OP_RSB: begin
            add_a = shift.operand; add_b = ~item.rn_value; add_cin = 1'b1; arith = 1'b1;
         end
         OP_ADD, OP_CMN: begin
            arith = 1'b1;
         end
         OP_ADC: begin
            add_cin = cflag; arith = 1'b1;
         end
         OP_SBC: begin
            add_b = ~shift.operand; add_cin = cflag; arith = 1'b1;
         end
         OP_RSC: begin
            add_a = shift.operand; add_b = ~item.rn_value; add_cin = cflag; arith = 1'b1;
         end
         default: ;
      endcase

      sum = {1'b0, add_a} + {1'b0, add_b} + {{WORD_BITS{1'b0}}, add_cin};

      unique case (op)
         OP_AND, OP_TST: res = item.rn_value & shift.operand;
         OP_EOR, OP_TEQ: res = item.rn_value ^ shift.operand;
         OP_ORR:         res = item.rn_value | shift.operand;
         OP_MOV:         res = shift.operand;
         OP_BIC:         res = item.rn_value & ~shift.operand;
         OP_MVN:         res = ~shift.operand;
         default:        res = sum[WORD_BITS-1:0];
      endcase

      if (arith) begin
         c = sum[WORD_BITS];
         v = ~(add_a[WORD_BITS-1] ^ add_b[WORD_BITS-1]) &
             (add_a[WORD_BITS-1] ^ res[WORD_BITS-1]);
      end else begin
         c = shift.carry;
         v = vflag;
      end

      wreg  = !test_op;
      flags = sbit;
      st    = ST_DONE;

      // Test opcodes without the S bit encode status reads or other instructions.
      if (test_op && !sbit) begin
         if (!item.instr[25] && (op == OP_TST || op == OP_CMP)) begin
            res  = (op == OP_CMP) ? item.spsr_in : item.cpsr_in;
            wreg = 1'b1;
         end else begin
            res = '0;
            st  = ST_NOT_HANDLED;
         end
      end

      cpsr_o = item.cpsr_in;
      wcpsr  = 1'b0;
      if (flags) begin
         if (wreg && rd == PC_REG) begin
            if (item.spsr_exists) begin
               cpsr_o = item.spsr_in;
               wcpsr  = 1'b1;
            end else begin
               st = ST_UNPRED;
            end
         end else begin
            cpsr_o = {res[WORD_BITS-1], (res == '0), c, v, item.cpsr_in[27:0]};
            wcpsr  = 1'b1;
         end
      end

      rsp.result     = res;
      rsp.dest_reg   = rd;
      rsp.write_reg  = wreg;
      rsp.cpsr_out   = cpsr_o;
      rsp.write_cpsr = wcpsr;
      rsp.status     = st;
   end

endmodule

`default_nettype wire

// ===== rtl/core/arm_data_processing_execute_top.sv =====
// Execute stage: input register, shifter and ALU, result register.
// An accepted item is held in the input register and moves to the result register once that side can take it.
// Throughput: one item per cycle while the result side is not stalled; the path is one shifter and one 32-bit adder.
// A full result register that is not taken stalls the input register, which
// still accepts while empty or while it can move on.
// Synchronous active-high reset clears both valid flags; payload is not reset.
`default_nettype none

module arm_data_processing_execute_top
   import dpx_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_item,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_item
);

   logic          s1_valid_ff;
   logic          s1_valid_in;
   req_type       s1_item_ff;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   rsp_type       rsp_item_ff;
   rsp_type       alu_rsp;
   shift_out_type shift;
   logic          s2_ready;

   assign s2_ready  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || s2_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s2_ready) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_item_ff <= req_item;
      end
      if (s1_valid_ff && s2_ready) begin
         rsp_item_ff <= alu_rsp;
      end
   end

   dpx_shifter u_shifter (
      .instr (s1_item_ff.instr),
      .rm    (s1_item_ff.rm_value),
      .rs    (s1_item_ff.rs_value),
      .cin   (s1_item_ff.cpsr_in[29]),
      .shift (shift)
   );

   dpx_alu u_alu (
      .item  (s1_item_ff),
      .shift (shift),
      .rsp   (alu_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // An item in the input register moves on whenever the result side can take it.
   a_advance: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_ready |=> rsp_valid_ff)
      else $error("item in input register was not moved to the result register");

   // A refused write to r15 still writes Rd but never the status register.
   a_unpred: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.status == ST_UNPRED |->
         !rsp_item_ff.write_cpsr && rsp_item_ff.write_reg && rsp_item_ff.dest_reg == PC_REG)
      else $error("unpredictable status with inconsistent write enables");

   // An instruction that is not handled writes nothing.
   a_not_handled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.status == ST_NOT_HANDLED |->
         !rsp_item_ff.write_reg && !rsp_item_ff.write_cpsr && rsp_item_ff.result == '0)
      else $error("unhandled instruction produced a write");

   // A completed test opcode exists only to set the flags.
   a_test_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_item_ff.write_reg && rsp_item_ff.status == ST_DONE |->
         rsp_item_ff.write_cpsr)
      else $error("test opcode finished without a flag update");

endmodule

`default_nettype wire
